/* rtl/htq_pkg.sv */
// ----------------------------------------------------------------------------
// htq_pkg
// Shared constants, payload structs and controller/datapath interface types
// for the heap timer queue.
// ----------------------------------------------------------------------------
package htq_pkg;

    localparam int CAPACITY    = 64;
    localparam int ID_COUNT    = 1024;
    localparam int MAX_RESULTS = 64;

    localparam int HEAP_AW = $clog2(CAPACITY);
    localparam int CNT_W   = HEAP_AW + 1;
    localparam int ID_AW   = $clog2(ID_COUNT);
    localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
    localparam int ID_W    = 10;
    localparam int TMO_W   = 24;
    localparam int TIME_W  = 32;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_ADJUST = 3'd1;
    localparam logic [2:0] OP_FIRE   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    localparam logic [TMO_W-1:0] DELAY_MAX = '1;

    typedef struct packed {
        logic [2:0]       op;
        logic [ID_W-1:0]  id;
        logic [TMO_W-1:0] timeout;
    } htq_in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  timer_id;
        logic [TMO_W-1:0] next_delay;
        logic             has_next;
        logic             last;
    } htq_out_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] exp;
    } htq_entry_t;

    typedef enum logic [2:0] {
        HA_ROOT,
        HA_SLOT,
        HA_LAST,
        HA_CHILD,
        HA_PARENT
    } htq_ha_sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_LOOK_HEAP,
        ST_LOOK_CHK,
        ST_REM_DEC,
        ST_REM_RD,
        ST_REM_LD,
        ST_SINK_RD,
        ST_SINK_SEL,
        ST_SINK_MOV,
        ST_RISE_RD,
        ST_RISE_CMP,
        ST_PLACE,
        ST_ROOT_RD,
        ST_ROOT_CHK
    } htq_state_t;

    typedef struct packed {
        logic        load;
        logic        clr_step;
        logic        clear;
        logic        pos_slot;
        logic        set_new;
        logic        set_restart;
        logic        set_kind;
        logic [1:0]  kind;
        logic        rem_begin;
        logic        rem_load;
        logic        sink_sel;
        logic        sink_mov;
        logic        rise_mov;
        logic        place;
        logic        tick_inc;
        logic        tick_take;
        logic        emit;
        logic        last;
        htq_ha_sel_t ha_sel;
    } htq_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       valid_id;
        logic       known;
        logic       full;
        logic       clr_last;
        logic       s_lt_cnt;
        logic       has_child;
        logic       sink_go;
        logic       moved;
        logic       rise_go;
        logic       expired;
        logic       pend;
    } htq_stat_t;

endpackage

/* rtl/heap_timer_queue.sv */
// ----------------------------------------------------------------------------
// heap_timer_queue
// Timer queue on a binary min-heap ordered by expiry, with an id-to-slot map.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item (op, id, timeout) and raise start; the transaction is taken at
//   the clock edge where start is high and busy is low. Busy stays high until
//   the last result of that transaction is on the result ports, so the next
//   transaction can be taken at the edge that takes that result.
//   Results appear on result for exactly one cycle with result_valid high;
//   the receiver cannot stall, so capture them as they come. The final
//   result of each transaction carries last.
//   A clear, an unused code or a tick with nothing expired goes straight to
//   the root check; an id lookup reads the presence and slot maps, then the
//   heap. An insert or restart sifts the timer, a fire sifts the last timer
//   into the freed slot; a level risen is a parent read and compare, a level
//   sunk a child read, select and move. A tick takes each expired timer in
//   turn, one result each, at most 64; one transaction is in flight.
//   After reset the presence memory is swept, one id per cycle, over all
//   1024 ids with busy high; all timers are gone and the time base is zero.
// ----------------------------------------------------------------------------
module heap_timer_queue
    import htq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  htq_in_t  item,
    output logic     result_valid,
    output htq_out_t result
);

    htq_cmd_t  cmd;
    htq_stat_t stat;

    // controller: walks each transaction through lookup, sift and issue
    htq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: holds the heap, the maps, the time base and the result
    htq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* rtl/htq_dp.sv */
// ----------------------------------------------------------------------------
// htq_dp
// Datapath: heap, id-to-slot map and presence memories, sift registers,
// time base and result register.
// ----------------------------------------------------------------------------
module htq_dp
    import htq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  htq_cmd_t  cmd,
    output htq_stat_t stat,
    input  htq_in_t   item,
    output logic      result_valid,
    output htq_out_t  result
);

    // memories
    logic             pres_mem [ID_COUNT];
    logic [HEAP_AW-1:0] slot_mem [ID_COUNT];
    htq_entry_t       heap_mem [CAPACITY];

    logic               pres_q;
    logic [HEAP_AW-1:0] slot_q;
    htq_entry_t         ha_q;
    htq_entry_t         hb_q;

    // transaction registers
    logic [2:0]       op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [TMO_W-1:0] tmo_reg;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]  now_reg;
    logic [ID_AW-1:0]   clr_idx_reg;
    logic [NRES_W-1:0]  nres_reg;
    logic               pend_reg;
    logic [1:0]         kind_reg;
    logic [ID_W-1:0]    tid_reg;
    logic [HEAP_AW-1:0] s_reg, s_next;
    logic [HEAP_AW-1:0] start_reg;
    htq_entry_t         e_reg;
    logic [TIME_W-1:0]  ek_reg;
    htq_entry_t         child_reg;
    logic [TIME_W-1:0]  ckey_reg;
    logic [HEAP_AW-1:0] cidx_reg;
    logic               valid_reg;
    htq_out_t           result_reg;

    logic [ID_AW-1:0]   id_idx;
    logic [CNT_W-1:0]   c_w;
    logic [CNT_W:0]     c1_w;
    logic [HEAP_AW-1:0] s_m1;
    logic [HEAP_AW-1:0] parent;
    logic [HEAP_AW-1:0] ha_addr;
    logic [TIME_W-1:0]  ka, kb;
    logic               pick_b;
    logic [TIME_W-1:0]  new_exp;
    logic [TMO_W-1:0]   delay;

    logic               heap_we;
    htq_entry_t         heap_wdata;
    logic               pres_we;
    logic [ID_AW-1:0]   pres_waddr;
    logic               pres_wdata;

    assign id_idx  = ID_AW'(id_reg);
    assign c_w     = {s_reg, 1'b1};
    assign c1_w    = {1'b0, c_w} + 1'b1;
    assign s_m1    = s_reg - 1'b1;
    assign parent  = {1'b0, s_m1[HEAP_AW-1:1]};
    assign ka      = ha_q.exp - now_reg;
    assign kb      = hb_q.exp - now_reg;
    assign pick_b  = (c1_w < {1'b0, cnt_reg}) && ($signed(kb) < $signed(ka));
    assign new_exp = now_reg + TIME_W'(tmo_reg);

    always_comb
    begin
        case (cmd.ha_sel)
            HA_ROOT:   ha_addr = '0;
            HA_SLOT:   ha_addr = slot_q;
            HA_LAST:   ha_addr = cnt_reg[HEAP_AW-1:0];
            HA_CHILD:  ha_addr = c_w[HEAP_AW-1:0];
            HA_PARENT: ha_addr = parent;
            default:   ha_addr = '0;
        endcase
    end

    // status towards the controller
    always_comb
    begin
        stat.op        = op_reg;
        stat.valid_id  = 32'(id_reg) < 32'(ID_COUNT);
        stat.known     = pres_q && ({1'b0, slot_q} < cnt_reg) && (ha_q.id == id_reg);
        stat.full      = cnt_reg >= CNT_W'(CAPACITY);
        stat.clr_last  = clr_idx_reg == ID_AW'(ID_COUNT - 1);
        stat.s_lt_cnt  = {1'b0, s_reg} < cnt_reg;
        stat.has_child = c_w < cnt_reg;
        stat.sink_go   = $signed(ek_reg) > $signed(ckey_reg);
        stat.moved     = s_reg != start_reg;
        stat.rise_go   = (s_reg != '0) && ($signed(ka) > $signed(ek_reg));
        stat.expired   = (cnt_reg != '0) && ((ka == '0) || ka[TIME_W-1])
                         && (nres_reg < NRES_W'(MAX_RESULTS));
        stat.pend      = pend_reg;
    end

    // saturated delay to the root's expiry
    always_comb
    begin
        if (cnt_reg == '0 || ka[TIME_W-1])
        begin
            delay = '0;
        end
        else if (|ka[TIME_W-2:TMO_W])
        begin
            delay = DELAY_MAX;
        end
        else
        begin
            delay = ka[TMO_W-1:0];
        end
    end

    // memory write selection
    always_comb
    begin
        heap_we = cmd.sink_mov | cmd.rise_mov | cmd.place;
        if (cmd.sink_mov)
        begin
            heap_wdata = child_reg;
        end
        else if (cmd.rise_mov)
        begin
            heap_wdata = ha_q;
        end
        else
        begin
            heap_wdata = e_reg;
        end
        pres_we    = cmd.clr_step | cmd.set_new;
        pres_waddr = cmd.clr_step ? clr_idx_reg : id_idx;
        pres_wdata = cmd.set_new;
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[s_reg]                  <= heap_wdata;
            slot_mem[ID_AW'(heap_wdata.id)] <= s_reg;
        end
        if (pres_we)
        begin
            pres_mem[pres_waddr] <= pres_wdata;
        end
        ha_q   <= heap_mem[ha_addr];
        hb_q   <= heap_mem[c1_w[HEAP_AW-1:0]];
        pres_q <= pres_mem[id_idx];
        slot_q <= slot_mem[id_idx];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.set_new)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.rem_begin)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        s_next = s_reg;
        if (cmd.pos_slot)
        begin
            s_next = slot_q;
        end
        else if (cmd.set_new)
        begin
            s_next = cnt_reg[HEAP_AW-1:0];
        end
        else if (cmd.sink_mov)
        begin
            s_next = cidx_reg;
        end
        else if (cmd.rise_mov)
        begin
            s_next = parent;
        end
        else if (cmd.tick_take)
        begin
            s_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            now_reg     <= '0;
            clr_idx_reg <= '0;
            nres_reg    <= '0;
            pend_reg    <= 1'b0;
            kind_reg    <= KIND_DONE;
            valid_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= cmd.emit;
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.load)
            begin
                pend_reg <= 1'b0;
                kind_reg <= KIND_DONE;
            end
            if (cmd.set_kind)
            begin
                kind_reg <= cmd.kind;
            end
            if (cmd.tick_inc)
            begin
                now_reg  <= now_reg + 1'b1;
                nres_reg <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.tick_take)
            begin
                pend_reg <= 1'b1;
                nres_reg <= nres_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        if (cmd.load)
        begin
            op_reg  <= item.op;
            id_reg  <= item.id;
            tmo_reg <= item.timeout;
        end
        if (cmd.set_new || cmd.set_restart)
        begin
            e_reg.id  <= id_reg;
            e_reg.exp <= new_exp;
            ek_reg    <= TIME_W'(tmo_reg);
        end
        if (cmd.set_restart)
        begin
            start_reg <= s_reg;
        end
        if (cmd.rem_load)
        begin
            e_reg     <= ha_q;
            ek_reg    <= ka;
            start_reg <= s_reg;
        end
        if (cmd.sink_sel)
        begin
            child_reg <= pick_b ? hb_q : ha_q;
            ckey_reg  <= pick_b ? kb : ka;
            cidx_reg  <= pick_b ? c1_w[HEAP_AW-1:0] : c_w[HEAP_AW-1:0];
        end
        if (cmd.tick_take)
        begin
            tid_reg <= ha_q.id;
        end
        if (cmd.emit)
        begin
            result_reg.kind       <= pend_reg ? KIND_FIRED : kind_reg;
            result_reg.timer_id   <= pend_reg ? tid_reg : id_reg;
            result_reg.next_delay <= delay;
            result_reg.has_next   <= cnt_reg != '0;
            result_reg.last       <= cmd.last;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/htq_ctrl.sv */
// ----------------------------------------------------------------------------
// htq_ctrl
// Controller: sequences lookup, insertion, removal, sifting, tick expiry
// and result issue over the datapath.
// ----------------------------------------------------------------------------
module htq_ctrl
    import htq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  htq_stat_t stat,
    output htq_cmd_t  cmd,
    output logic      busy
);

    htq_state_t state_reg, state_next;
    logic       take;

    assign take = (stat.op == OP_TICK) && stat.expired;
    assign busy = state_reg != ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            ST_IDLE:
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            ST_DECODE:
                if ((stat.op == OP_ADD || stat.op == OP_ADJUST || stat.op == OP_FIRE)
                    && stat.valid_id)
                begin
                    state_next = ST_LOOK_HEAP;
                end
                else
                begin
                    state_next = ST_ROOT_RD;
                end
            ST_LOOK_HEAP:
                state_next = ST_LOOK_CHK;
            ST_LOOK_CHK:
                if (!stat.known)
                begin
                    state_next = (stat.op == OP_ADD && !stat.full) ? ST_RISE_RD : ST_ROOT_RD;
                end
                else if (stat.op == OP_FIRE)
                begin
                    state_next = ST_REM_DEC;
                end
                else
                begin
                    state_next = ST_SINK_RD;
                end
            ST_REM_DEC:
                state_next = ST_REM_RD;
            ST_REM_RD:
                state_next = stat.s_lt_cnt ? ST_REM_LD : ST_ROOT_RD;
            ST_REM_LD:
                state_next = ST_SINK_RD;
            ST_SINK_RD:
                if (stat.has_child)
                begin
                    state_next = ST_SINK_SEL;
                end
                else
                begin
                    state_next = stat.moved ? ST_PLACE : ST_RISE_RD;
                end
            ST_SINK_SEL:
                state_next = ST_SINK_MOV;
            ST_SINK_MOV:
                if (stat.sink_go)
                begin
                    state_next = ST_SINK_RD;
                end
                else
                begin
                    state_next = stat.moved ? ST_PLACE : ST_RISE_RD;
                end
            ST_RISE_RD:
                state_next = ST_RISE_CMP;
            ST_RISE_CMP:
                state_next = stat.rise_go ? ST_RISE_RD : ST_PLACE;
            ST_PLACE:
                state_next = ST_ROOT_RD;
            ST_ROOT_RD:
                state_next = ST_ROOT_CHK;
            ST_ROOT_CHK:
                state_next = take ? ST_REM_DEC : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.ha_sel = HA_ROOT;
        case (state_reg)
            ST_INIT:
                cmd.clr_step = 1'b1;
            ST_IDLE:
                cmd.load = start;
            ST_DECODE:
                case (stat.op)
                    OP_ADD, OP_ADJUST, OP_FIRE:
                        if (!stat.valid_id)
                        begin
                            cmd.set_kind = 1'b1;
                            cmd.kind     = KIND_UNKNOWN;
                        end
                    OP_TICK:
                        cmd.tick_inc = 1'b1;
                    OP_CLEAR:
                        cmd.clear = 1'b1;
                    default:
                        cmd.clear = 1'b0;
                endcase
            ST_LOOK_HEAP:
            begin
                cmd.ha_sel   = HA_SLOT;
                cmd.pos_slot = 1'b1;
            end
            ST_LOOK_CHK:
                if (stat.known)
                begin
                    if (stat.op == OP_FIRE)
                    begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = KIND_FIRED;
                    end
                    else
                    begin
                        cmd.set_restart = 1'b1;
                    end
                end
                else if (stat.op == OP_ADD)
                begin
                    if (stat.full)
                    begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = KIND_FULL;
                    end
                    else
                    begin
                        cmd.set_new = 1'b1;
                    end
                end
                else
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = KIND_UNKNOWN;
                end
            ST_REM_DEC:
                cmd.rem_begin = 1'b1;
            ST_REM_RD:
                cmd.ha_sel = HA_LAST;
            ST_REM_LD:
                cmd.rem_load = 1'b1;
            ST_SINK_RD:
                cmd.ha_sel = HA_CHILD;
            ST_SINK_SEL:
                cmd.sink_sel = 1'b1;
            ST_SINK_MOV:
                cmd.sink_mov = stat.sink_go;
            ST_RISE_RD:
                cmd.ha_sel = HA_PARENT;
            ST_RISE_CMP:
                cmd.rise_mov = stat.rise_go;
            ST_PLACE:
                cmd.place = 1'b1;
            ST_ROOT_RD:
                cmd.ha_sel = HA_ROOT;
            ST_ROOT_CHK:
            begin
                cmd.emit      = stat.pend || !take;
                cmd.last      = !take;
                cmd.tick_take = take;
            end
            default:
                cmd.load = 1'b0;
        endcase
    end

endmodule

/* verif/heap_timer_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_timer_queue_tb
// Self-checking bench: drives timer commands in bursts, predicts every result
// with a behavioural heap model and compares each result field by field.
// ----------------------------------------------------------------------------
module heap_timer_queue_tb;
    import htq_pkg::*;

    // ------------------------------------------------------------------------
    // Behavioural model of the timer queue plus the store of expected results
    // ------------------------------------------------------------------------
    class timer_scoreboard;
        htq_entry_t heap_q[CAPACITY];
        logic [HEAP_AW-1:0] slot_map[ID_COUNT];
        bit present[ID_COUNT];
        int unsigned fill;
        logic [TIME_W-1:0] now;
        htq_out_t pending[$];
        int errors;
        int fired_seen;
        int full_seen;
        int unknown_seen;

        function new();
            fill = 0;
            now = '0;
            errors = 0;
            fired_seen = 0;
            full_seen = 0;
            unknown_seen = 0;
            foreach (present[i]) present[i] = 1'b0;
        endfunction

        // Ordering key: distance from now, with the sign bit flipped
        function logic [31:0] key_of(int unsigned s);
            return (heap_q[s].exp - now) ^ 32'h8000_0000;
        endfunction

        function void swap_at(int unsigned a, int unsigned b);
            htq_entry_t t;
            t = heap_q[a];
            heap_q[a] = heap_q[b];
            heap_q[b] = t;
            slot_map[heap_q[a].id] = HEAP_AW'(a);
            slot_map[heap_q[b].id] = HEAP_AW'(b);
        endfunction

        function void sift_up(int unsigned s);
            int unsigned p;
            while (s > 0) begin
                p = (s - 1) / 2;
                if (key_of(p) > key_of(s)) begin
                    swap_at(p, s);
                    s = p;
                end
                else break;
            end
        endfunction

        function bit sift_down(int unsigned s, int unsigned n);
            int unsigned org;
            int unsigned c;
            org = s;
            c = 2 * s + 1;
            while (c < n) begin
                if (c + 1 < n && key_of(c + 1) < key_of(c)) c++;
                if (key_of(s) > key_of(c)) begin
                    swap_at(s, c);
                    s = c;
                    c = 2 * s + 1;
                end
                else break;
            end
            return s > org;
        endfunction

        function void drop_slot(int unsigned s);
            int unsigned n;
            n = fill - 1;
            if (s < n) begin
                swap_at(s, n);
                if (!sift_down(s, n)) sift_up(s);
            end
            present[heap_q[n].id] = 1'b0;
            fill = n;
        endfunction

        function void push_result(logic [1:0] kind, logic [ID_W-1:0] tid);
            htq_out_t r;
            logic [31:0] d;
            r.kind = kind;
            r.timer_id = tid;
            r.next_delay = '0;
            if (fill > 0) begin
                d = heap_q[0].exp - now;
                if (d[31]) r.next_delay = '0;
                else if (d > 32'(DELAY_MAX)) r.next_delay = DELAY_MAX;
                else r.next_delay = d[TMO_W-1:0];
            end
            r.has_next = (fill > 0);
            r.last = 1'b0;
            pending.insert(pending.size(), r);
        endfunction

        // Note an accepted transaction and queue the results it causes
        function void note_command(htq_in_t cmd);
            logic [1:0] kind;
            int unsigned s;
            int n;
            logic [31:0] d;
            logic [ID_W-1:0] tid;
            kind = KIND_DONE;
            n = 0;
            if (cmd.op == OP_TICK) begin
                now = now + 1;
                while (fill > 0 && n < MAX_RESULTS) begin
                    d = heap_q[0].exp - now;
                    if (d != 0 && !d[31]) break;
                    tid = heap_q[0].id;
                    drop_slot(0);
                    push_result(KIND_FIRED, tid);
                    n++;
                end
                if (n == 0) push_result(KIND_DONE, cmd.id);
            end
            else begin
                if (cmd.op == OP_CLEAR) begin
                    fill = 0;
                    foreach (present[i]) present[i] = 1'b0;
                end
                else if (cmd.op == OP_ADD) begin
                    if (present[cmd.id]) begin
                        s = slot_map[cmd.id];
                        heap_q[s].exp = now + TIME_W'(cmd.timeout);
                        if (!sift_down(s, fill)) sift_up(s);
                    end
                    else if (fill >= CAPACITY) kind = KIND_FULL;
                    else begin
                        s = fill;
                        heap_q[s].id = cmd.id;
                        heap_q[s].exp = now + TIME_W'(cmd.timeout);
                        slot_map[cmd.id] = HEAP_AW'(s);
                        present[cmd.id] = 1'b1;
                        fill = s + 1;
                        sift_up(s);
                    end
                end
                else if (cmd.op == OP_ADJUST || cmd.op == OP_FIRE) begin
                    if (!present[cmd.id]) kind = KIND_UNKNOWN;
                    else if (cmd.op == OP_ADJUST) begin
                        s = slot_map[cmd.id];
                        heap_q[s].exp = now + TIME_W'(cmd.timeout);
                        if (!sift_down(s, fill)) sift_up(s);
                    end
                    else begin
                        drop_slot(slot_map[cmd.id]);
                        kind = KIND_FIRED;
                    end
                end
                push_result(kind, cmd.id);
            end
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // Compare one result with the oldest expectation
        task check_result(htq_out_t got);
            htq_out_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.kind == KIND_FIRED) fired_seen++;
            if (got.kind == KIND_FULL) full_seen++;
            if (got.kind == KIND_UNKNOWN) unknown_seen++;
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.timer_id !== want.timer_id)
                report($sformatf("timer_id %0d, want %0d", got.timer_id, want.timer_id));
            if (got.next_delay !== want.next_delay)
                report($sformatf("next_delay %0d, want %0d",
                                 got.next_delay, want.next_delay));
            if (got.has_next !== want.has_next)
                report($sformatf("has_next %0b, want %0b", got.has_next, want.has_next));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    htq_in_t  item;
    logic     result_valid;
    htq_out_t result;

    timer_scoreboard sb;
    int sent;

    heap_timer_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Capture every strobed result; the receiver can never hold one off
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1) sb.check_result(result);
    end

    // Present one transaction and hold it until the block takes it
    task automatic send_cmd(logic [2:0] op, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo);
        htq_in_t cmd;
        cmd.op = op;
        cmd.id = id;
        cmd.timeout = tmo;
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        sb.note_command(cmd);
        sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drain: wait until every expected result has arrived
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy !== 1'b0) @(posedge clk);
    endtask

    // Pick an id biased towards a small pool so add/adjust/fire collide
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) return ID_W'($urandom);
        return ID_W'($urandom_range(0, 47));
    endfunction

    function automatic logic [TMO_W-1:0] pick_timeout();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DELAY_MAX;
            2: return TMO_W'($urandom);
            default: return TMO_W'($urandom_range(0, 12));
        endcase
    endfunction

    task automatic random_phase(int count);
        int burst;
        logic [2:0] op;
        int r;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && count > 0) begin
                r = $urandom_range(0, 99);
                if (r < 35) op = OP_ADD;
                else if (r < 50) op = OP_ADJUST;
                else if (r < 62) op = OP_FIRE;
                else if (r < 95) op = OP_TICK;
                else if (r < 97) op = OP_CLEAR;
                else op = 3'($urandom_range(5, 7));
                send_cmd(op, pick_id(), pick_timeout());
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 20));
        end
    endtask

    initial
    begin
        sb    = new();
        sent  = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue answers, unused codes, extremes of fields
        send_cmd(OP_TICK, 10'h3FF, '0);
        send_cmd(OP_FIRE, 10'd5, '0);
        send_cmd(OP_ADJUST, 10'h3FF, DELAY_MAX);
        send_cmd(3'd5, 10'h2AA, 24'h555555);
        send_cmd(3'd7, 10'h155, 24'hAAAAAA);
        send_cmd(OP_ADD, 10'h3FF, DELAY_MAX);
        send_cmd(OP_ADD, 10'd0, '0);
        send_cmd(OP_ADD, 10'd1, 24'd2);
        send_cmd(OP_ADD, 10'd2, 24'd2);     // equal expiry to id 1, rises past id 3FF
        send_cmd(OP_ADD, 10'd1, 24'd5);     // restart, stays in its leaf slot
        send_cmd(OP_ADJUST, 10'h3FF, 24'd1); // adjust rises, stops below the root
        send_cmd(OP_TICK, 10'd9, '0);
        send_cmd(OP_TICK, 10'd9, '0);
        send_cmd(OP_FIRE, 10'd1, '0);
        send_cmd(OP_FIRE, 10'd1, '0);
        send_cmd(OP_CLEAR, 10'd0, '0);
        drain();

        // Fill the heap, overflow it, then expire all at once in one tick
        for (int i = 0; i < CAPACITY; i++)
            send_cmd(OP_ADD, ID_W'(100 + i), TMO_W'($urandom_range(0, 1)));
        send_cmd(OP_ADD, 10'd900, 24'd3);
        send_cmd(OP_TICK, 10'd0, '0);
        send_cmd(OP_TICK, 10'd0, '0);
        drain();

        random_phase(140);
        drain();  // sender pauses until every result is in
        random_phase(140);
        drain();
        repeat (200) @(posedge clk);

        $display("Covered %0d transactions: %0d timers fired, %0d heap-full and %0d",
                 sent, sb.fired_seen, sb.full_seen, sb.unknown_seen);
        $display("unknown-id answers, with fill to capacity and bulk expiry.");
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: generous bound for reset sweep plus worst-case heap work
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
